// ----- design/least_squares_line_fit_top_defines.svh -----
// Assertion macros for the line-fit RTL.
// Self-contained; included by files that carry concurrent assertions.
`ifndef LEAST_SQUARES_LINE_FIT_TOP_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check
`define LSLF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication check
`define LSLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define LSLF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LSLF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/lslf_pkg.sv -----
// Shared types, widths and codes for the least-squares line fit block.
// No dependencies; imported by the controller, the datapath and the top level.
package lslf_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_W    = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_W      = 13;            // holds MAX_POINTS itself
  localparam int CTR_W      = COORD_W + 1;   // centered coordinate, signed
  localparam int SUM_W      = 25;            // sum of x or y, signed
  localparam int SQ_W       = 38;            // sum of x*y or x*x, signed
  localparam int A_W        = 52;            // wide multiplier operand, num and den
  localparam int DIG_W      = 13;            // multiplier digit
  localparam int B_W        = 2 * DIG_W;     // narrow multiplier operand
  localparam int PROD_W     = 78;            // product and intercept numerator
  localparam int FRAC_W     = 16;            // Q16.16 fraction bits
  localparam int DIVN_W     = PROD_W + FRAC_W;
  localparam int DIVD_W     = 64;            // divisor
  localparam int RES_W      = 32;
  localparam int Q_W        = RES_W + 1;
  localparam int DCNT_W     = $clog2(DIVN_W);

  localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET      = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET     = CFG_DATA_W'(480);

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } lslf_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    logic [CNT_W-1:0]        point_count;
    logic                    degenerate;
    logic                    saturated;
  } lslf_out_t;

  // Products of the fit, in the order the controller runs them
  typedef enum logic [2:0] {
    OP_NSXY,
    OP_SXSY,
    OP_NSXX,
    OP_SXSX,
    OP_DENSY,
    OP_NUMSX,
    OP_NDEN
  } mul_op_t;

  typedef struct packed {
    logic    take_point;
    logic    mul_load;
    logic    mul_step;
    logic    mul_wb;
    mul_op_t mul_op;
    logic    check;
    logic    div_load;
    logic    div_step;
    logic    div_wb;
    logic    div_sel;     // 0: slope, 1: intercept
    logic    load_out;
    logic    clear_sums;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic div_last;
    logic degen;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/lslf_ctrl.sv -----
// Sequencer for the line fit: point intake, product sequence, two divisions.
// Depends on lslf_pkg; drives the datapath through dp_cmd_t.
module lslf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_stall,
  input  lslf_pkg::dp_status_t status,
  output lslf_pkg::dp_cmd_t    cmd
);
  import lslf_pkg::*;

  typedef enum logic [3:0] {
    S_ACCEPT,
    S_DRAIN,
    S_MLOAD,
    S_MRUN,
    S_MWB,
    S_CHECK,
    S_DLOAD,
    S_DRUN,
    S_DWB,
    S_FINISH
  } state_t;

  state_t  state;
  mul_op_t op;
  logic    div_sel;

  function automatic mul_op_t next_op(input mul_op_t cur);
    case (cur)
      OP_NSXY:  return OP_SXSY;
      OP_SXSY:  return OP_NSXX;
      OP_NSXX:  return OP_SXSX;
      OP_SXSX:  return OP_DENSY;
      OP_DENSY: return OP_NUMSX;
      OP_NUMSX: return OP_NDEN;
      default:  return OP_NSXY;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_ACCEPT;
      op      <= OP_NSXY;
      div_sel <= 1'b0;
    end else begin
      case (state)
        S_ACCEPT: begin
          if (in_valid && in_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          op    <= OP_NSXY;
          state <= S_MLOAD;
        end
        S_MLOAD: state <= S_MRUN;
        S_MRUN: begin
          if (status.mul_last) state <= S_MWB;
        end
        S_MWB: begin
          case (op)
            OP_SXSX: state <= S_CHECK;
            OP_NDEN: begin
              div_sel <= 1'b0;
              state   <= S_DLOAD;
            end
            default: begin
              op    <= next_op(op);
              state <= S_MLOAD;
            end
          endcase
        end
        S_CHECK: begin
          // skip the last products and the divisions on an empty set or a horizontal spread of zero
          if (status.degen) begin
            state <= S_FINISH;
          end else begin
            op    <= OP_DENSY;
            state <= S_MLOAD;
          end
        end
        S_DLOAD: state <= S_DRUN;
        S_DRUN: begin
          if (status.div_last) state <= S_DWB;
        end
        S_DWB: begin
          if (!div_sel) begin
            div_sel <= 1'b1;
            state   <= S_DLOAD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (status.out_free) state <= S_ACCEPT;
        end
        default: state <= S_ACCEPT;
      endcase
    end
  end

  assign in_stall = (state != S_ACCEPT);

  always_comb begin
    cmd            = '0;
    cmd.mul_op     = op;
    cmd.div_sel    = div_sel;
    cmd.take_point = (state == S_ACCEPT) && in_valid;
    cmd.mul_load   = (state == S_MLOAD);
    cmd.mul_step   = (state == S_MRUN);
    cmd.mul_wb     = (state == S_MWB);
    cmd.check      = (state == S_CHECK);
    cmd.div_load   = (state == S_DLOAD);
    cmd.div_step   = (state == S_DRUN);
    cmd.div_wb     = (state == S_DWB);
    cmd.load_out   = (state == S_FINISH) && status.out_free;
    cmd.clear_sums = (state == S_FINISH) && status.out_free;
  end

endmodule

// ----- design/lslf_dp.sv -----
// Datapath of the line fit: centering, running sums, digit-serial multiplier,
// restoring divider and output register. Depends on lslf_pkg and the defines header.
`include "least_squares_line_fit_top_defines.svh"
module lslf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lslf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lslf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lslf_pkg::lslf_in_t            in_data,
  input  lslf_pkg::dp_cmd_t             cmd,
  output lslf_pkg::dp_status_t          status,
  input  logic                          out_stall,
  output logic                          out_valid,
  output lslf_pkg::lslf_out_t           out_data
);
  import lslf_pkg::*;

  // configuration
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;

  // staged point and running sums
  logic                     stage_valid;
  logic signed [CTR_W-1:0]  x_q;
  logic signed [CTR_W-1:0]  y_q;
  logic [CNT_W-1:0]         count;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [SQ_W-1:0]   sum_xy;
  logic signed [SQ_W-1:0]   sum_xx;

  // multiplier
  logic [A_W-1:0]    mag_a;
  logic [B_W-1:0]    mag_b;
  logic              mul_neg;
  logic              mul_dig;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] tmp;
  logic [A_W-1:0]    num;
  logic [A_W-1:0]    den;
  logic [PROD_W-1:0] inum;
  logic [DIVD_W-1:0] nden;

  // divider
  logic [DIVN_W-1:0] dvd;
  logic [DIVD_W-1:0] dvs;
  logic [DIVD_W-1:0] rem;
  logic [Q_W-1:0]    quo;
  logic              q_ovf;
  logic              div_neg;
  logic [DCNT_W-1:0] div_cnt;

  // fit results
  logic [RES_W-1:0] slope_r;
  logic [RES_W-1:0] icpt_r;
  logic             degen_r;
  logic             sat_r;

  function automatic logic [A_W-1:0] mag_w(input logic [A_W-1:0] v);
    return v[A_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [B_W-1:0] mag_n(input logic [B_W-1:0] v);
    return v[B_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DIVN_W-1:0] mag_dvd(input logic [DIVN_W-1:0] v);
    return v[DIVN_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DIVD_W-1:0] mag_dvs(input logic [DIVD_W-1:0] v);
    return v[DIVD_W-1] ? (~v + 1'b1) : v;
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- centering and accumulation ----------------
  logic [COORD_W-1:0]      half_w;
  logic [COORD_W-1:0]      half_h;
  logic signed [B_W-1:0]   xy;
  logic signed [B_W-1:0]   xx;

  assign half_w = image_width[CFG_DATA_W-1:1];
  assign half_h = image_height[CFG_DATA_W-1:1];
  assign xy = {{(B_W-CTR_W){x_q[CTR_W-1]}}, x_q} * {{(B_W-CTR_W){y_q[CTR_W-1]}}, y_q};
  assign xx = {{(B_W-CTR_W){x_q[CTR_W-1]}}, x_q} * {{(B_W-CTR_W){x_q[CTR_W-1]}}, x_q};

  always_ff @(posedge clk) begin
    if (cmd.take_point) begin
      x_q <= signed'({1'b0, in_data.point_x} - {1'b0, half_w});
      y_q <= signed'({1'b0, half_h} - {1'b0, in_data.point_y});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      count       <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      sum_xy      <= '0;
      sum_xx      <= '0;
    end else begin
      stage_valid <= cmd.take_point;
      if (cmd.clear_sums) begin
        count  <= '0;
        sum_x  <= '0;
        sum_y  <= '0;
        sum_xy <= '0;
        sum_xx <= '0;
      end else if (stage_valid && (count < CNT_W'(MAX_POINTS))) begin
        // drop points once the set is full
        count  <= count + 1'b1;
        sum_x  <= sum_x + {{(SUM_W-CTR_W){x_q[CTR_W-1]}}, x_q};
        sum_y  <= sum_y + {{(SUM_W-CTR_W){y_q[CTR_W-1]}}, y_q};
        sum_xy <= sum_xy + {{(SQ_W-B_W){xy[B_W-1]}}, xy};
        sum_xx <= sum_xx + {{(SQ_W-B_W){xx[B_W-1]}}, xx};
      end
    end
  end

  // ---------------- multiplier: two digits of DIG_W bits ----------------
  logic [A_W-1:0]       op_a;
  logic [B_W-1:0]       op_b;
  logic [B_W-1:0]       n_b;
  logic [DIG_W-1:0]     digit;
  logic [A_W+DIG_W-1:0] pp;
  logic [PROD_W-1:0]    pp_ext;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    diff;

  assign n_b = {{(B_W-CNT_W){1'b0}}, count};

  always_comb begin
    case (cmd.mul_op)
      OP_NSXY: begin
        op_a = {{(A_W-SQ_W){sum_xy[SQ_W-1]}}, sum_xy};
        op_b = n_b;
      end
      OP_SXSY: begin
        op_a = {{(A_W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
        op_b = {{(B_W-SUM_W){sum_y[SUM_W-1]}}, sum_y};
      end
      OP_NSXX: begin
        op_a = {{(A_W-SQ_W){sum_xx[SQ_W-1]}}, sum_xx};
        op_b = n_b;
      end
      OP_SXSX: begin
        op_a = {{(A_W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
        op_b = {{(B_W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
      end
      OP_DENSY: begin
        op_a = den;
        op_b = {{(B_W-SUM_W){sum_y[SUM_W-1]}}, sum_y};
      end
      OP_NUMSX: begin
        op_a = num;
        op_b = {{(B_W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
      end
      OP_NDEN: begin
        op_a = den;
        op_b = n_b;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign digit  = mul_dig ? mag_b[B_W-1:DIG_W] : mag_b[DIG_W-1:0];
  assign pp     = {{DIG_W{1'b0}}, mag_a} * {{A_W{1'b0}}, digit};
  assign pp_ext = {{(PROD_W-A_W-DIG_W){1'b0}}, pp};
  assign prod   = mul_neg ? (~acc + 1'b1) : acc;
  assign diff   = tmp - prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_dig <= 1'b0;
    end else if (cmd.mul_load) begin
      mul_dig <= 1'b0;
    end else if (cmd.mul_step) begin
      mul_dig <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mag_a   <= mag_w(op_a);
      mag_b   <= mag_n(op_b);
      mul_neg <= op_a[A_W-1] ^ op_b[B_W-1];
      acc     <= '0;
    end else if (cmd.mul_step) begin
      acc <= acc + (mul_dig ? (pp_ext << DIG_W) : pp_ext);
    end
    if (cmd.mul_wb) begin
      case (cmd.mul_op)
        OP_NSXY:  tmp  <= prod;
        OP_SXSY:  num  <= diff[A_W-1:0];
        OP_NSXX:  tmp  <= prod;
        OP_SXSX:  den  <= diff[A_W-1:0];
        OP_DENSY: tmp  <= prod;
        OP_NUMSX: inum <= diff;
        OP_NDEN:  nden <= prod[DIVD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- restoring divider, one quotient bit a cycle ----------------
  logic [DIVN_W-1:0] dvd_src;
  logic [DIVD_W-1:0] dvs_src;
  logic [DIVD_W:0]   rem_sh;
  logic              rem_ge;
  logic [DIVD_W:0]   rem_sub;
  logic              pos_sat;
  logic              neg_sat;
  logic              div_sat;
  logic [RES_W-1:0]  div_res;

  assign dvd_src = cmd.div_sel ? {inum, {FRAC_W{1'b0}}}
                               : {{(PROD_W-A_W){num[A_W-1]}}, num, {FRAC_W{1'b0}}};
  assign dvs_src = cmd.div_sel ? nden : {{(DIVD_W-A_W){den[A_W-1]}}, den};
  assign rem_sh  = {rem, dvd[DIVN_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // quotient bits above the low Q_W are folded into q_ovf
  assign pos_sat = q_ovf || (quo[Q_W-1:Q_W-2] != 2'b00);
  assign neg_sat = q_ovf || (quo > {1'b0, RES_MIN});
  assign div_sat = div_neg ? neg_sat : pos_sat;
  assign div_res = div_neg ? (neg_sat ? RES_MIN : (~quo[RES_W-1:0] + 1'b1))
                           : (pos_sat ? RES_MAX : quo[RES_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd     <= mag_dvd(dvd_src);
      dvs     <= mag_dvs(dvs_src);
      div_neg <= dvd_src[DIVN_W-1] ^ dvs_src[DIVD_W-1];
      rem     <= '0;
      quo     <= '0;
      q_ovf   <= 1'b0;
    end else if (cmd.div_step) begin
      dvd   <= dvd << 1;
      rem   <= rem_ge ? rem_sub[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
      quo   <= {quo[Q_W-2:0], rem_ge};
      q_ovf <= q_ovf | quo[Q_W-1];
    end
  end

  // ---------------- fit results and output register ----------------
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      degen_r <= status.degen;
      slope_r <= '0;
      icpt_r  <= '0;
      sat_r   <= 1'b0;
    end else if (cmd.div_wb) begin
      if (cmd.div_sel) icpt_r <= div_res;
      else             slope_r <= div_res;
      sat_r <= sat_r | div_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.slope       <= signed'(slope_r);
      out_data.intercept   <= signed'(icpt_r);
      out_data.point_count <= count;
      out_data.degenerate  <= degen_r;
      out_data.saturated   <= sat_r;
    end
  end

  assign status.mul_last = mul_dig;
  assign status.div_last = (div_cnt == DCNT_W'(DIVN_W - 1));
  assign status.degen    = (count == '0) || (den == '0);
  assign status.out_free = !out_valid || !out_stall;

  `LSLF_ASSERT_IMPL(a_degen_zero, clk, rst, out_valid && out_data.degenerate, out_data.slope == '0 && out_data.intercept == '0 && !out_data.saturated)
  `LSLF_ASSERT_IMPL(a_den_nonneg, clk, rst, cmd.check, !den[A_W-1])
  `LSLF_ASSERT_NEXT(a_sums_cleared, clk, rst, cmd.clear_sums, count == '0 && sum_x == '0 && sum_xy == '0)
  `LSLF_ASSERT_IMPL(a_count_cap, clk, rst, stage_valid, count <= CNT_W'(MAX_POINTS))

endmodule

// ----- design/least_squares_line_fit_top.sv -----
// Least-squares line fit, top level: controller plus datapath.
// Depends on lslf_pkg, lslf_ctrl and lslf_dp.
//
// Usage:
//   Points arrive on in_valid/in_stall/in_data, one transfer per cycle while
//   a set streams in. Each point is centered on the image and added to the
//   running count and sums. The point flagged last_point closes the set.
//   After the last transfer in_stall stays high while the fit runs: seven
//   two-digit products, two 94-step divisions, plus drain, check and
//   output load; an empty or degenerate set runs only four products and the
//   check, then skips the divisions.
//   The fit time is set by the one-bit-per-cycle restoring divider.
//   Results leave on out_valid/out_stall/out_data from an output register,
//   so a new set streams in while a result waits. If a second fit ends
//   before the first result is taken, the block holds until it is.
//   cfg_we/cfg_index/cfg_data write image width (index 0) and height
//   (index 1); write only while idle.
//   Synchronous reset: width 640, height 480, sums cleared, no result pending.
module least_squares_line_fit_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lslf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lslf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lslf_pkg::lslf_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lslf_pkg::lslf_out_t             out_data
);
  import lslf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lslf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_point),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lslf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for least_squares_line_fit_top: streams pixel point sets,
// predicts every line fit in exact wide integer arithmetic and compares each result.
// Depends on lslf_pkg and the least_squares_line_fit_top RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lslf_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int    COORD_MAX  = (1 << COORD_W) - 1;
  localparam int    CFG_MAX    = (1 << CFG_DATA_W) - 1;
  localparam int    RAND_ITEMS = 800;
  localparam int    NUM_PHASES = 6;
  localparam int    FIT_CYCLES = 250;
  localparam wide_t Q_TOP      = 128'sd2147483647;
  localparam wide_t Q_BOTTOM   = -128'sd2147483648;

  class fit_scoreboard;
    logic [CFG_DATA_W-1:0] img_w;
    logic [CFG_DATA_W-1:0] img_h;
    int                    n_pts;
    longint                sum_x, sum_y, sum_xy, sum_xx;
    lslf_out_t             pending_fits[$];
    int                    errors;

    function new();
      img_w  = WIDTH_RESET;
      img_h  = HEIGHT_RESET;
      errors = 0;
      restart_set();
    endfunction

    function void restart_set();
      n_pts  = 0;
      sum_x  = 0;
      sum_y  = 0;
      sum_xy = 0;
      sum_xx = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) begin
        img_w = val;
      end else if (idx == REG_IMAGE_HEIGHT) begin
        img_h = val;
      end
    endfunction

    // Truncating division, clipped to the Q16.16 range
    function logic [RES_W-1:0] q16_quot(wide_t a, wide_t b, output bit clip);
      wide_t q;
      q = a / b;
      clip = (q > Q_TOP) || (q < Q_BOTTOM);
      if (q > Q_TOP) return RES_MAX;
      if (q < Q_BOTTOM) return RES_MIN;
      return q[RES_W-1:0];
    endfunction

    function void note_point(lslf_in_t p);
      longint    x, y;
      wide_t     n, sx, sy, num, den;
      lslf_out_t fit;
      bit        clip_a, clip_b;
      // a full set drops further points, the closing one included
      if (n_pts < MAX_POINTS) begin
        x = longint'(p.point_x) - longint'(img_w >> 1);
        y = longint'(img_h >> 1) - longint'(p.point_y);
        n_pts++;
        sum_x  += x;
        sum_y  += y;
        sum_xy += x * y;
        sum_xx += x * x;
      end
      if (!p.last_point) return;
      n   = n_pts;
      sx  = sum_x;
      sy  = sum_y;
      num = n * sum_xy - sx * sy;
      den = n * sum_xx - sx * sx;
      fit = '0;
      fit.point_count = CNT_W'(n_pts);
      if (n_pts == 0 || den == 0) begin
        fit.degenerate = 1'b1;
      end else begin
        fit.slope     = q16_quot(num <<< FRAC_W, den, clip_a);
        fit.intercept = q16_quot((sy * den - num * sx) <<< FRAC_W, n * den, clip_b);
        fit.saturated = clip_a | clip_b;
      end
      pending_fits.push_back(fit);
      restart_set();
    endfunction

    function void check_fit(lslf_out_t got);
      lslf_out_t want;
      if (pending_fits.size() == 0) begin
        $error("unexpected fit: slope %0d, intercept %0d, point_count %0d",
               got.slope, got.intercept, got.point_count);
        errors++;
        return;
      end
      want = pending_fits.pop_front();
      if (got.slope !== want.slope) begin
        $error("slope: expected %0d, got %0d", want.slope, got.slope);
        errors++;
      end
      if (got.intercept !== want.intercept) begin
        $error("intercept: expected %0d, got %0d", want.intercept, got.intercept);
        errors++;
      end
      if (got.point_count !== want.point_count) begin
        $error("point_count: expected %0d, got %0d", want.point_count, got.point_count);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  lslf_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lslf_out_t             out_data;

  fit_scoreboard sb = new();
  bit            steady = 1'b0;
  int            stall_left = 0;

  least_squares_line_fit_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none in steady stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lslf_in_t pt(int x, int y, bit last);
    lslf_in_t p;
    p.point_x    = COORD_W'(x < 0 ? 0 : (x > COORD_MAX ? COORD_MAX : x));
    p.point_y    = COORD_W'(y < 0 ? 0 : (y > COORD_MAX ? COORD_MAX : y));
    p.last_point = last;
    return p;
  endfunction

  // Enter and leave at a falling edge; valid stays up into back-to-back transfers
  task automatic send_point(lslf_in_t p);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_point(p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Hold until every fit is out and the divider has surely gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_fits.size() != 0) @(negedge clk);
    repeat (FIT_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_set(output int n);
    int kind, bx, by, dx, dy, x, y;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
    kind = $urandom_range(0, 9);
    bx   = $urandom_range(0, COORD_MAX);
    by   = $urandom_range(0, COORD_MAX);
    dx   = $urandom_range(0, 6) - 3;
    dy   = $urandom_range(0, 80) - 40;
    for (int i = 0; i < n; i++) begin
      if (kind < 4) begin
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
      end else if (kind < 8) begin
        // noisy straight line
        x = bx + i * dx + $urandom_range(0, 1);
        y = by + i * dy + $urandom_range(0, 4) - 2;
      end else begin
        // one column only: zero denominator
        x = bx;
        y = $urandom_range(0, COORD_MAX);
      end
      send_point(pt(x, y, i == n - 1));
    end
  endtask

  // Two-point steep lines far from center push the intercept out of range
  task automatic send_steep_pairs();
    send_point(pt(4094, 0, 1'b0));
    send_point(pt(4095, 4095, 1'b1));
    send_point(pt(4094, 4095, 1'b0));
    send_point(pt(4095, 0, 1'b1));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_fit(out_data);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    int sent, n;
    logic [CFG_DATA_W-1:0] w_sel [4] = '{CFG_DATA_W'(1), CFG_DATA_W'(0),
                                         CFG_DATA_W'(CFG_MAX), CFG_DATA_W'(4096)};
    logic [CFG_DATA_W-1:0] h_sel [4] = '{CFG_DATA_W'(1), CFG_DATA_W'(0),
                                         CFG_DATA_W'(CFG_MAX), CFG_DATA_W'(4096)};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single points and a single column: degenerate; then a pair and a triple
    send_point(pt(0, 0, 1'b1));
    send_point(pt(COORD_MAX, COORD_MAX, 1'b1));
    send_point(pt(320, 0, 1'b0));
    send_point(pt(320, COORD_MAX, 1'b1));
    send_point(pt(0, 0, 1'b0));
    send_point(pt(COORD_MAX, COORD_MAX, 1'b1));
    send_point(pt(12'hAAA, 12'h555, 1'b0));
    send_point(pt(12'h555, 12'hAAA, 1'b0));
    send_point(pt(0, COORD_MAX, 1'b1));
    // flat line, then a corner-to-corner pair
    send_point(pt(10, 240, 1'b0));
    send_point(pt(630, 240, 1'b0));
    send_point(pt(320, 240, 1'b1));
    send_point(pt(0, COORD_MAX, 1'b0));
    send_point(pt(COORD_MAX, 0, 1'b1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(REG_IMAGE_WIDTH, ph < 4 ? w_sel[ph] : CFG_DATA_W'($urandom_range(0, CFG_MAX)));
      write_reg(REG_IMAGE_HEIGHT, ph < 4 ? h_sel[ph] : CFG_DATA_W'($urandom_range(0, CFG_MAX)));
      if (ph < 2) send_steep_pairs();
      sent = 0;
      while (sent < RAND_ITEMS / NUM_PHASES) begin
        steady = ($urandom_range(0, 4) == 0);
        send_random_set(n);
        sent += n;
      end
    end
    steady = 1'b0;

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/lslf_pkg.sv
design/lslf_ctrl.sv
design/lslf_dp.sv
design/least_squares_line_fit_top.sv
tb/sv/tb.sv
